// ===== hw/rtl/bdlp_pkg.sv =====
// ---------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debounce and long-press block.
// ---------------------------------------------------------------------------
package bdlp_pkg;

  // width of the free-running microsecond time base
  localparam int unsigned TimeBits = 48;
  // width of the configuration registers
  localparam int unsigned CfgBits  = 24;

  // register reset values in microseconds
  localparam logic [CfgBits-1:0] DebounceReset = CfgBits'(200000);
  localparam logic [CfgBits-1:0] HoldReset     = CfgBits'(1000000);

  // button codes
  typedef enum logic [1:0] {
    BtnOn     = 2'd0,
    BtnOff    = 2'd1,
    BtnToggle = 2'd2
  } btn_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    CfgDebounce = 1'b0,
    CfgHold     = 1'b1
  } cfg_idx_e;

  // configuration register set
  typedef struct packed {
    logic [CfgBits-1:0] debounce_time;
    logic [CfgBits-1:0] hold_time;
  } cfg_t;

  // one button event
  typedef struct packed {
    logic [1:0]          button;
    logic                level;
    logic [TimeBits-1:0] timestamp;
  } event_t;

  // one result
  typedef struct packed {
    logic accepted;
    logic led_one;
    logic led_two;
    logic blink_mode;
  } result_t;

endpackage

// ===== hw/rtl/bdlp_ifs.sv =====
// ---------------------------------------------------------------------------
// bdlp interfaces
// Valid/ready channels for button events and for results.
// ---------------------------------------------------------------------------

// button event channel
interface bdlp_evt_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    button;
  logic                          level;
  logic [bdlp_pkg::TimeBits-1:0] timestamp;

  modport source (output valid, output button, output level, output timestamp,
                  input ready);
  modport sink   (input valid, input button, input level, input timestamp,
                  output ready);
endinterface

// result channel
interface bdlp_res_if;
  logic valid;
  logic ready;
  logic accepted;
  logic led_one;
  logic led_two;
  logic blink_mode;

  modport source (output valid, output accepted, output led_one, output led_two,
                  output blink_mode, input ready);
  modport sink   (input valid, input accepted, input led_one, input led_two,
                  input blink_mode, output ready);
endinterface

// ===== hw/rtl/bdlp_cfg.sv =====
// ---------------------------------------------------------------------------
// bdlp_cfg
// Configuration registers: debounce time and long-press hold time.
// ---------------------------------------------------------------------------
module bdlp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [bdlp_pkg::CfgBits-1:0] cfg_wdata_i,
  output bdlp_pkg::cfg_t               cfg_o
);

  bdlp_pkg::cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bdlp_pkg::cfg_idx_e'(cfg_idx_i))
        bdlp_pkg::CfgDebounce: cfg_d.debounce_time = cfg_wdata_i;
        bdlp_pkg::CfgHold:     cfg_d.hold_time     = cfg_wdata_i;
        default:               cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time <= bdlp_pkg::DebounceReset;
      cfg_q.hold_time     <= bdlp_pkg::HoldReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/bdlp_core.sv =====
// ---------------------------------------------------------------------------
// bdlp_core
// Per-button debounce check, toggle press timing and LED state update.
// ---------------------------------------------------------------------------
module bdlp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bdlp_pkg::cfg_t    cfg_i,
  input  logic              fire_i,
  input  bdlp_pkg::event_t  evt_i,
  output bdlp_pkg::result_t res_o
);

  localparam int unsigned TB = bdlp_pkg::TimeBits;

  logic [TB-1:0] last_q [3];
  logic [TB-1:0] last_d [3];
  logic [TB-1:0] press_q, press_d;
  logic          led_one_q, led_one_d;
  logic          led_two_q, led_two_d;
  logic          blink_q, blink_d;

  logic          btn_ok;
  logic [TB-1:0] last_sel;
  logic [TB-1:0] since;
  logic [TB-1:0] held;
  logic          pass;
  logic          long_press;

  // last accepted time of the addressed button
  always_comb begin
    btn_ok   = 1'b1;
    last_sel = last_q[0];
    case (evt_i.button)
      bdlp_pkg::BtnOn:     last_sel = last_q[0];
      bdlp_pkg::BtnOff:    last_sel = last_q[1];
      bdlp_pkg::BtnToggle: last_sel = last_q[2];
      default:             btn_ok   = 1'b0;
    endcase
  end

  // debounce and hold checks, wrapping time differences
  assign since      = evt_i.timestamp - last_sel;
  assign held       = evt_i.timestamp - press_q;
  assign pass       = btn_ok && (since >= TB'(cfg_i.debounce_time));
  assign long_press = held >= TB'(cfg_i.hold_time);

  // state update for an accepted event
  always_comb begin
    last_d    = last_q;
    press_d   = press_q;
    led_one_d = led_one_q;
    led_two_d = led_two_q;
    blink_d   = blink_q;
    if (pass) begin
      last_d[evt_i.button] = evt_i.timestamp;
      case (evt_i.button)
        bdlp_pkg::BtnOn:  led_one_d = 1'b1;
        bdlp_pkg::BtnOff: led_one_d = 1'b0;
        bdlp_pkg::BtnToggle: begin
          if (!evt_i.level) begin
            press_d = evt_i.timestamp;
          end else if (long_press) begin
            blink_d = !blink_q;
          end else if (!blink_q) begin
            led_two_d = !led_two_q;
          end
        end
        default: ;
      endcase
    end
  end

  // result reflects state after the event
  assign res_o.accepted   = pass;
  assign res_o.led_one    = led_one_d;
  assign res_o.led_two    = led_two_d;
  assign res_o.blink_mode = blink_d;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '{default: '0};
      press_q   <= '0;
      led_one_q <= 1'b0;
      led_two_q <= 1'b0;
      blink_q   <= 1'b0;
    end else if (fire_i) begin
      last_q    <= last_d;
      press_q   <= press_d;
      led_one_q <= led_one_d;
      led_two_q <= led_two_d;
      blink_q   <= blink_d;
    end
  end

  // an ignored event leaves all LED state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !pass |=> $stable(led_one_q) && $stable(led_two_q) && $stable(blink_q))
    else $error("ignored event changed LED state");

  // an accepted off press clears the first LED
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && pass && (evt_i.button == bdlp_pkg::BtnOff) |=> !led_one_q)
    else $error("off button did not clear LED one");

  // one release never flips both blink mode and the second LED
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> !(($past(blink_q) != blink_q) && ($past(led_two_q) != led_two_q)))
    else $error("blink mode and LED two flipped together");

  // the second LED holds while blinking stays on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q && fire_i && blink_d |=> $stable(led_two_q))
    else $error("LED two changed while blinking");

endmodule

// ===== hw/rtl/button_debounce_long_press_led.sv =====
// ---------------------------------------------------------------------------
// button_debounce_long_press_led
// Debounced on/off/toggle buttons driving LED one, LED two and blink mode.
// ---------------------------------------------------------------------------
// Takes one button event transaction per clock while the result register can
// advance, and returns one result per event. An event passes through an input
// register, a single subtract-and-compare step against the button's last
// accepted time (and the press start for a toggle release) that also updates
// the LED state, and a result register, so back to back events see each
// other's effect. Configuration writes go to index 0 (debounce time) and
// index 1 (hold time), both in microseconds.
module button_debounce_long_press_led (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [bdlp_pkg::CfgBits-1:0] cfg_wdata_i,
  bdlp_evt_if.sink                     evt_i,
  bdlp_res_if.source                   res_o
);

  bdlp_pkg::cfg_t    cfg;
  bdlp_pkg::event_t  in_q;
  bdlp_pkg::result_t core_res;
  bdlp_pkg::result_t res_q;
  logic              in_valid_q;
  logic              res_valid_q;
  logic              advance;
  logic              fire;

  // handshake: the result register frees the input stage
  assign advance     = !res_valid_q || res_o.ready;
  assign fire        = in_valid_q && advance;
  assign evt_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      in_q.button    <= evt_i.button;
      in_q.level     <= evt_i.level;
      in_q.timestamp <= evt_i.timestamp;
    end
  end

  bdlp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdlp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .evt_i  (in_q),
    .res_o  (core_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= core_res;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.accepted   = res_q.accepted;
  assign res_o.led_one    = res_q.led_one;
  assign res_o.led_two    = res_q.led_two;
  assign res_o.blink_mode = res_q.blink_mode;

endmodule
